// ===== src/rbsi_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, register indexes and word types of the ray/box slab tester.
// ---------------------------------------------------------------------------
package rbsi_pkg;

  localparam int CW    = 32;          // coordinate width, signed
  localparam int FB    = 16;          // fraction bits
  localparam int TW    = 16;          // tag width
  localparam int RW    = 31;          // reach / t width
  localparam int QW    = CW - 1;      // quotient bits below saturation
  localparam int MW    = CW + FB;     // scaled dividend width
  localparam int NAX   = 3;
  localparam int NLN   = 2 * NAX;
  localparam int IDXW  = 3;

  typedef enum logic [IDXW-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_REACH    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
    logic [TW-1:0]        box_tag;
  } box_t;

  typedef struct packed {
    logic                 hit;
    logic [RW-1:0]        hit_t;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
    logic [TW-1:0]        result_tag;
  } result_t;

  typedef struct packed {
    logic [NAX-1:0][CW-1:0] origin;
    logic [NAX-1:0][CW-1:0] dir;
    logic [RW-1:0]          reach;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] mag;
    logic          neg;
  } quo_t;

  typedef struct packed {
    quo_t          qa;
    quo_t          qb;
    logic [CW-1:0] ud;
    logic          zero;
    logic          enclosed;
  } axis_t;

  typedef struct packed {
    axis_t [NAX-1:0] ax;
    logic [TW-1:0]   tag;
  } front_word_t;

  typedef struct packed {
    logic [CW-1:0] p;
    logic [QW-1:0] dq;
    logic          sat;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [NLN-1:0]        ln;
    logic [NAX-1:0][CW-1:0] ud;
    logic [NAX-1:0]         zero;
    logic [NAX-1:0]         enclosed;
    logic [TW-1:0]          tag;
  } div_word_t;

endpackage
`default_nettype wire

// ===== src/rbsi_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_front
// Ray registers, box intake, corner offsets and zero-direction classification.
// ---------------------------------------------------------------------------
module rbsi_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [rbsi_pkg::IDXW-1:0]    cfg_index,
  input  wire  [rbsi_pkg::CW-1:0]      cfg_data,
  output rbsi_pkg::cfg_t               cfg,
  input  wire                          push,
  output logic                         full,
  input  rbsi_pkg::box_t               box,
  output logic                         fw_valid,
  input  wire                          fw_ready,
  output rbsi_pkg::front_word_t        fw
);
  import rbsi_pkg::*;

  logic signed [CW-1:0] bmin [NAX];
  logic signed [CW-1:0] bmax [NAX];
  front_word_t          fw_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin <= '0;
      cfg.dir    <= {{(2*CW){1'b0}}, CW'(1 << FB)};
      cfg.reach  <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: cfg.origin[0] <= cfg_data;
        REG_ORIGIN_Y: cfg.origin[1] <= cfg_data;
        REG_ORIGIN_Z: cfg.origin[2] <= cfg_data;
        REG_DIR_X:    cfg.dir[0]    <= cfg_data;
        REG_DIR_Y:    cfg.dir[1]    <= cfg_data;
        REG_DIR_Z:    cfg.dir[2]    <= cfg_data;
        REG_REACH:    cfg.reach     <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  assign bmin[0] = box.box_min_x;
  assign bmin[1] = box.box_min_y;
  assign bmin[2] = box.box_min_z;
  assign bmax[0] = box.box_max_x;
  assign bmax[1] = box.box_max_y;
  assign bmax[2] = box.box_max_z;

  always_comb begin
    logic signed [CW:0]   o, d, na, nb;
    logic signed [CW-1:0] oc;
    fw_next = '0;
    for (int i = 0; i < NAX; i++) begin
      oc = $signed(cfg.origin[i]);
      o  = {oc[CW-1], oc};
      d  = {cfg.dir[i][CW-1], cfg.dir[i]};
      na = {bmin[i][CW-1], bmin[i]} - o;
      nb = {bmax[i][CW-1], bmax[i]} - o;
      fw_next.ax[i].qa.mag = na[CW] ? CW'(-na) : na[CW-1:0];
      fw_next.ax[i].qa.neg = na[CW] ^ d[CW];
      fw_next.ax[i].qb.mag = nb[CW] ? CW'(-nb) : nb[CW-1:0];
      fw_next.ax[i].qb.neg = nb[CW] ^ d[CW];
      fw_next.ax[i].ud     = d[CW] ? CW'(-d) : d[CW-1:0];
      fw_next.ax[i].zero   = (d == '0);
      fw_next.ax[i].enclosed = (oc >= bmin[i] && oc <= bmax[i]) ||
                               (oc >= bmax[i] && oc <= bmin[i]);
    end
    fw_next.tag = box.box_tag;
  end

  assign full = fw_valid && !fw_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (push && !full) begin
      fw_valid <= 1'b1;
    end else if (fw_ready) begin
      fw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      fw <= fw_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/rbsi_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_queue
// Two-entry queue of classified box words between front and back.
// ---------------------------------------------------------------------------
module rbsi_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  rbsi_pkg::front_word_t  in_word,
  output logic                   out_valid,
  input  wire                    out_ready,
  output rbsi_pkg::front_word_t  out_word
);
  import rbsi_pkg::*;

  front_word_t mem [2];
  logic        wp, rp;
  logic [1:0]  count;
  logic        wr, rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;
  assign out_word  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_word;
  end

endmodule
`default_nettype wire

// ===== src/rbsi_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_back
// Pipelined slab dividers, interval merge, hit point and result queue.
// ---------------------------------------------------------------------------
module rbsi_back (
  input  wire                    clk,
  input  wire                    rst,
  input  rbsi_pkg::cfg_t         cfg,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  rbsi_pkg::front_word_t  in_word,
  output logic                   empty,
  input  wire                    pop,
  output rbsi_pkg::result_t      result
);
  import rbsi_pkg::*;

  function automatic lane_t lane_init(quo_t q, logic [CW-1:0] ud);
    lane_t            l;
    logic [MW-1:0]    n;
    logic [CW+QW-1:0] nn, dd;
    n     = {q.mag, {FB{1'b0}}};
    nn    = (CW+QW)'(n);
    dd    = {ud, {QW{1'b0}}};
    l.p   = CW'(n[MW-1:QW]);
    l.dq  = n[QW-1:0];
    l.sat = (nn >= dd);
    l.neg = q.neg;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [CW-1:0] ud);
    lane_t       r;
    logic [CW:0] ps;
    logic        ge;
    ps    = {l.p, l.dq[QW-1]};
    ge    = (ps >= {1'b0, ud});
    r     = l;
    r.p   = ge ? CW'(ps - {1'b0, ud}) : ps[CW-1:0];
    r.dq  = {l.dq[QW-2:0], ge};
    return r;
  endfunction

  logic             en;
  logic             dv [QW+1];
  div_word_t        dw [QW+1];
  div_word_t        dw_init;

  logic                   a_valid;
  logic signed [CW-1:0]   a_min [NAX];
  logic signed [CW-1:0]   a_max [NAX];
  logic [NAX-1:0]         a_act;
  logic                   a_ok;
  logic [NAX-1:0][CW-1:0] a_ud;
  logic [TW-1:0]          a_tag;

  logic                   b_valid, b_hit;
  logic [RW-1:0]          b_t;
  logic [NAX-1:0][CW-1:0] b_ud;
  logic [TW-1:0]          b_tag;

  logic                   c_valid, c_hit;
  logic [RW-1:0]          c_t;
  logic [CW+RW-1:0]       c_prod [NAX];
  logic [TW-1:0]          c_tag;

  result_t                res;
  result_t                oq [2];
  logic                   oq_wp, oq_rp;
  logic [1:0]             oq_count;
  logic                   oq_full, oq_push, oq_pop;

  assign oq_full  = (oq_count == 2'd2);
  assign en       = !(c_valid && oq_full);
  assign in_ready = en;
  assign oq_push  = c_valid && !oq_full;
  assign oq_pop   = pop && !empty;
  assign empty    = (oq_count == 2'd0);
  assign result   = oq[oq_rp];

  always_comb begin
    dw_init = '0;
    for (int i = 0; i < NAX; i++) begin
      dw_init.ln[2*i]   = lane_init(in_word.ax[i].qa, in_word.ax[i].ud);
      dw_init.ln[2*i+1] = lane_init(in_word.ax[i].qb, in_word.ax[i].ud);
      dw_init.ud[i]     = in_word.ax[i].ud;
      dw_init.zero[i]   = in_word.ax[i].zero;
      dw_init.enclosed[i] = in_word.ax[i].enclosed;
    end
    dw_init.tag = in_word.tag;
  end

  // divider pipeline, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[0] <= in_valid;
      for (int k = 0; k < QW; k++) dv[k+1] <= dv[k];
    end
  end

  always_ff @(posedge clk) begin
    div_word_t nx;
    if (en) begin
      dw[0] <= dw_init;
      for (int k = 0; k < QW; k++) begin
        nx = dw[k];
        for (int j = 0; j < NLN; j++) begin
          nx.ln[j] = lane_step(dw[k].ln[j], dw[k].ud[j/2]);
        end
        dw[k+1] <= nx;
      end
    end
  end

  // signed quotients, ordered per axis
  always_ff @(posedge clk) begin
    logic [CW-1:0]        qv0, qv1;
    logic signed [CW-1:0] s0, s1;
    logic                 ok;
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= dv[QW];
    end
    if (en) begin
      ok = 1'b1;
      for (int i = 0; i < NAX; i++) begin
        qv0 = dw[QW].ln[2*i].sat   ? {1'b0, {QW{1'b1}}} : {1'b0, dw[QW].ln[2*i].dq};
        qv1 = dw[QW].ln[2*i+1].sat ? {1'b0, {QW{1'b1}}} : {1'b0, dw[QW].ln[2*i+1].dq};
        s0  = dw[QW].ln[2*i].neg   ? $signed(-qv0) : $signed(qv0);
        s1  = dw[QW].ln[2*i+1].neg ? $signed(-qv1) : $signed(qv1);
        a_min[i] <= (s1 < s0) ? s1 : s0;
        a_max[i] <= (s1 < s0) ? s0 : s1;
        if (dw[QW].zero[i] && !dw[QW].enclosed[i]) ok = 1'b0;
      end
      a_act <= ~dw[QW].zero;
      a_ok  <= ok;
      a_ud  <= dw[QW].ud;
      a_tag <= dw[QW].tag;
    end
  end

  // interval merge and range test
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] lo, hi;
    logic                 any;
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      lo  = {1'b1, {(CW-1){1'b0}}};
      hi  = {1'b0, {(CW-1){1'b1}}};
      any = 1'b0;
      for (int i = 0; i < NAX; i++) begin
        if (a_act[i]) begin
          if (a_min[i] > lo) lo = a_min[i];
          if (a_max[i] < hi) hi = a_max[i];
          any = 1'b1;
        end
      end
      b_hit <= a_ok && any && (lo <= hi) && (lo > 0) &&
               (lo[RW-1:0] <= cfg.reach);
      b_t   <= lo[RW-1:0];
      b_ud  <= a_ud;
      b_tag <= a_tag;
    end
  end

  // direction magnitude times t
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      for (int i = 0; i < NAX; i++) begin
        c_prod[i] <= b_ud[i] * b_t;
      end
      c_hit <= b_hit;
      c_t   <= b_t;
      c_tag <= b_tag;
    end
  end

  // hit point, saturated
  always_comb begin
    logic [CW+RW-FB-1:0]  mag;
    logic [CW:0]          cap;
    logic signed [CW+1:0] o, sum;
    logic signed [CW-1:0] pt [NAX];
    for (int i = 0; i < NAX; i++) begin
      mag = c_prod[i][CW+RW-1:FB];
      cap = (mag > (CW+RW-FB)'({1'b1, {CW{1'b0}}})) ? {1'b1, {CW{1'b0}}} : mag[CW:0];
      o   = (CW+2)'($signed(cfg.origin[i]));
      sum = cfg.dir[i][CW-1] ? o - $signed({1'b0, cap}) : o + $signed({1'b0, cap});
      if (sum > (CW+2)'($signed({1'b0, {(CW-1){1'b1}}}))) begin
        pt[i] = {1'b0, {(CW-1){1'b1}}};
      end else if (sum < (CW+2)'($signed({1'b1, {(CW-1){1'b0}}}))) begin
        pt[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pt[i] = sum[CW-1:0];
      end
    end
    res            = '0;
    res.result_tag = c_tag;
    if (c_hit) begin
      res.hit   = 1'b1;
      res.hit_t = c_t;
      res.hit_x = pt[0];
      res.hit_y = pt[1];
      res.hit_z = pt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp    <= 1'b0;
      oq_rp    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (oq_push) oq_wp <= ~oq_wp;
      if (oq_pop)  oq_rp <= ~oq_rp;
      oq_count <= oq_count + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq[oq_wp] <= res;
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (rst) oq_count != 2'd3)
    else $error("result queue overrun");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (c_valid && !en) |=> (c_valid && $stable(c_t) && $stable(c_tag)))
    else $error("stalled result moved");
  a_hit_t: assert property (@(posedge clk) disable iff (rst)
    (oq_push && res.hit) |-> (res.hit_t != '0))
    else $error("hit with zero t");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    (oq_push && !res.hit) |-> (res.hit_t == '0 && res.hit_x == '0))
    else $error("miss word not cleared");

endmodule
`default_nettype wire

// ===== src/ray_box_slab_intersect_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_top
// Ray against axis-aligned box slab test in signed Q16.16, one box a word.
// ---------------------------------------------------------------------------
//  channel  handshake              word
//  box      push / full            box_t: two corners and tag
//  result   empty / pop            result_t: hit, t, point, tag
//  config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One box word enters per cycle while full is low. Each word passes the
//  front register, the queue, the 31-stage divider pipeline (one quotient
//  bit per stage), then the quotient, merge, multiply and result stages.
//  Reset restores the default ray and empties both queues. When the result
//  queue is full and the multiply stage holds a result, the whole back
//  pipeline holds; the front and its queue keep taking words until they fill.
module ray_box_slab_intersect_top (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  output logic                       full,
  input  rbsi_pkg::box_t             box,
  output logic                       empty,
  input  wire                        pop,
  output rbsi_pkg::result_t          result,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [rbsi_pkg::IDXW-1:0]  cfg_index,
  input  wire  [rbsi_pkg::CW-1:0]    cfg_data
);
  import rbsi_pkg::*;

  cfg_t        cfg;
  logic        fw_valid, fw_ready;
  front_word_t fw;
  logic        bq_valid, bq_ready;
  front_word_t bq_word;

  rbsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .box       (box),
    .fw_valid  (fw_valid),
    .fw_ready  (fw_ready),
    .fw        (fw)
  );

  rbsi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fw_valid),
    .in_ready  (fw_ready),
    .in_word   (fw),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_word  (bq_word)
  );

  rbsi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (bq_valid),
    .in_ready (bq_ready),
    .in_word  (bq_word),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
`default_nettype wire
